// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cpwm_pkg.sv =====
// ------------------------------------------------------------------------
// cpwm_pkg
// Types and constants of the cubic polynomial warp map.
// ------------------------------------------------------------------------
package cpwm_pkg;

	localparam int TERM_COUNT = 10;
	localparam int COEF_SLOTS = 2 * TERM_COUNT;
	localparam int DIM_W      = 13;
	localparam int SCALE_W    = 32;
	localparam int COEF_W     = 32;
	localparam int IDX_W      = 5;
	localparam int COORD_W    = 12;
	localparam int NORM_FRAC  = 30;
	localparam int NORM_W     = 32;
	localparam int PROD_W     = 64;
	localparam int SUM_W      = 66;
	localparam int SRC_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_XSCALE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YSCALE = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_MAP   = 1'b1;

	localparam logic [DIM_W-1:0]   DIM_RST   = 13'd4096;
	localparam logic [SCALE_W-1:0] SCALE_RST = 32'd524416;

	localparam logic signed [NORM_W-1:0] NORM_ONE = 32'sh4000_0000;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sh0000_0000_2000_0000;
	localparam logic signed [SRC_W-1:0] SRC_MAX = 32'sh7fff_ffff;
	localparam logic signed [SRC_W-1:0] SRC_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [SCALE_W-1:0] x_scale;
		logic [SCALE_W-1:0] y_scale;
	} cfg_t;

	// what travels with every word until the coefficient stage
	typedef struct packed {
		logic                     is_map;
		logic [IDX_W-1:0]         idx;
		logic signed [COEF_W-1:0] val;
	} tag_t;

	typedef struct packed {
		tag_t                     tag;
		logic signed [NORM_W-1:0] x;
		logic signed [NORM_W-1:0] y;
	} norm_t;

	typedef struct packed {
		tag_t                                tag;
		logic [TERM_COUNT-1:0][NORM_W-1:0]   terms;
	} term_t;

	typedef struct packed {
		logic signed [SRC_W-1:0] src_x;
		logic signed [SRC_W-1:0] src_y;
		logic                    saturated;
	} result_t;

	// Q1.30 product, rounded half up
	function automatic logic signed [NORM_W-1:0] qmul(input logic signed [NORM_W-1:0] a,
			input logic signed [NORM_W-1:0] b);
		logic signed [PROD_W-1:0] p;
		p = a * b + ROUND_HALF;
		return p[NORM_FRAC +: NORM_W];
	endfunction

endpackage

// ===== rtl/cpwm_req_if.sv =====
// ------------------------------------------------------------------------
// cpwm_req_if
// Request channel: coefficient write or pixel map word.
// ------------------------------------------------------------------------
interface cpwm_req_if import cpwm_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [IDX_W-1:0]         coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic [COORD_W-1:0]       column;
	logic [COORD_W-1:0]       row;

	modport source (output valid, cmd, coef_index, coef_value, column, row, input ready);
	modport sink (input valid, cmd, coef_index, coef_value, column, row, output ready);
endinterface

// ===== rtl/cpwm_rsp_if.sv =====
// ------------------------------------------------------------------------
// cpwm_rsp_if
// Response channel: mapped source coordinates.
// ------------------------------------------------------------------------
interface cpwm_rsp_if import cpwm_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [SRC_W-1:0] src_x;
	logic signed [SRC_W-1:0] src_y;
	logic                    saturated;

	modport source (output valid, src_x, src_y, saturated, input ready);
	modport sink (input valid, src_x, src_y, saturated, output ready);
endinterface

// ===== rtl/cpwm_norm.sv =====
// ------------------------------------------------------------------------
// cpwm_norm
// Two stages: coordinate times scale, then offset, clamp and small-image zero.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module cpwm_norm import cpwm_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  tag_t               in_tag,
	input  logic [COORD_W-1:0] in_col,
	input  logic [COORD_W-1:0] in_row,
	output logic               out_valid,
	input  logic               out_ready,
	output norm_t              out_data
);

	localparam int CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int MW = CB + SCALE_W;
	localparam int DW = MW + 2;
	localparam logic signed [DW-1:0] ONE_D = DW'(NORM_ONE);

	logic          v_s1, v_s2;
	logic          adv_s1, adv_s2;
	tag_t          tag_s1;
	logic [MW-1:0] px_s1, py_s1;
	logic          zx_s1, zy_s1;
	norm_t         data_s2;

	function automatic logic signed [NORM_W-1:0] norm_clamp(input logic [MW-1:0] p,
			input logic z);
		logic signed [DW-1:0] d;
		d = $signed({2'b00, p}) - ONE_D;
		if (z)
			return '0;
		if (d > ONE_D)
			return NORM_ONE;
		if (d < -ONE_D)
			return -NORM_ONE;
		return d[NORM_W-1:0];
	endfunction

	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= in_valid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			tag_s1 <= in_tag;
			px_s1  <= MW'(in_col[CB-1:0]) * MW'(cfg.x_scale);
			py_s1  <= MW'(in_row[CB-1:0]) * MW'(cfg.y_scale);
			zx_s1  <= cfg.width <= DIM_W'(1);
			zy_s1  <= cfg.height <= DIM_W'(1);
		end
		if (adv_s2 && v_s1) begin
			data_s2.tag <= tag_s1;
			data_s2.x   <= norm_clamp(px_s1, zx_s1);
			data_s2.y   <= norm_clamp(py_s1, zy_s1);
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

	`ASSERT_IMPLY(a_norm_range, v_s2 && data_s2.tag.is_map,
		data_s2.x <= NORM_ONE && data_s2.x >= -NORM_ONE &&
		data_s2.y <= NORM_ONE && data_s2.y >= -NORM_ONE,
		"normalized coordinate outside [-1, 1]")

endmodule

// ===== rtl/cpwm_mono.sv =====
// ------------------------------------------------------------------------
// cpwm_mono
// Two stages forming the ten cubic monomials of the normalized point.
// ------------------------------------------------------------------------
module cpwm_mono import cpwm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  norm_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output term_t out_data
);

	logic                     v_s3, v_s4;
	logic                     adv_s3, adv_s4;
	tag_t                     tag_s3;
	logic signed [NORM_W-1:0] x_s3, y_s3, xx_s3, xy_s3, yy_s3;
	term_t                    term_s4;

	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign in_ready = adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s3)
				v_s3 <= in_valid;
			if (adv_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && in_valid) begin
			tag_s3 <= in_data.tag;
			x_s3   <= in_data.x;
			y_s3   <= in_data.y;
			xx_s3  <= qmul(in_data.x, in_data.x);
			xy_s3  <= qmul(in_data.x, in_data.y);
			yy_s3  <= qmul(in_data.y, in_data.y);
		end
		if (adv_s4 && v_s3) begin
			// order: 1, x, y, x2, xy, y2, x3, x2y, xy2, y3
			term_s4.tag      <= tag_s3;
			term_s4.terms[0] <= NORM_ONE;
			term_s4.terms[1] <= x_s3;
			term_s4.terms[2] <= y_s3;
			term_s4.terms[3] <= xx_s3;
			term_s4.terms[4] <= xy_s3;
			term_s4.terms[5] <= yy_s3;
			term_s4.terms[6] <= qmul(xx_s3, x_s3);
			term_s4.terms[7] <= qmul(xx_s3, y_s3);
			term_s4.terms[8] <= qmul(xy_s3, y_s3);
			term_s4.terms[9] <= qmul(yy_s3, y_s3);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = term_s4;

endmodule

// ===== rtl/cpwm_dot.sv =====
// ------------------------------------------------------------------------
// cpwm_dot
// Coefficient store, twenty products, registered adder tree, rounding and
// saturation into the output register.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module cpwm_dot import cpwm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  term_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	localparam int RW = SUM_W - NORM_FRAC;
	localparam logic signed [RW-1:0] R_MAX = RW'(SRC_MAX);
	localparam logic signed [RW-1:0] R_MIN = RW'(SRC_MIN);
	localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(ROUND_HALF);

	logic signed [COEF_W-1:0] coef_q [COEF_SLOTS];

	logic v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic adv_s5, adv_s6, adv_s7, adv_s8, adv_s9, adv_s10;

	logic signed [PROD_W-1:0] prod_s5 [2][TERM_COUNT];
	logic signed [SUM_W-1:0]  sum_s6 [2][5];
	logic signed [SUM_W-1:0]  sum_s7 [2][3];
	logic signed [SUM_W-1:0]  sum_s8 [2][2];
	logic signed [SUM_W-1:0]  sum_s9 [2];
	result_t                  res_s10;

	logic signed [SUM_W-1:0] rnd [2];
	logic signed [RW-1:0]    rq [2];
	logic signed [SRC_W-1:0] clip [2];
	logic [1:0]              sat;

	assign adv_s10  = !v_s10 || out_ready;
	assign adv_s9   = !v_s9 || adv_s10;
	assign adv_s8   = !v_s8 || adv_s9;
	assign adv_s7   = !v_s7 || adv_s8;
	assign adv_s6   = !v_s6 || adv_s7;
	assign adv_s5   = !v_s5 || adv_s6;
	assign in_ready = adv_s5;

	// coefficient writes take effect here, in order with the map words
	always_ff @(posedge clk) begin
		if (adv_s5 && in_valid && !in_data.tag.is_map &&
				in_data.tag.idx < IDX_W'(COEF_SLOTS))
			coef_q[in_data.tag.idx] <= in_data.tag.val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			// drop write words: they leave no result
			if (adv_s5)
				v_s5 <= in_valid && in_data.tag.is_map;
			if (adv_s6)
				v_s6 <= v_s5;
			if (adv_s7)
				v_s7 <= v_s6;
			if (adv_s8)
				v_s8 <= v_s7;
			if (adv_s9)
				v_s9 <= v_s8;
			if (adv_s10)
				v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && in_valid && in_data.tag.is_map) begin
			for (int p = 0; p < 2; p++) begin
				for (int k = 0; k < TERM_COUNT; k++) begin
					prod_s5[p][k] <= coef_q[p*TERM_COUNT+k] * $signed(in_data.terms[k]);
				end
			end
		end
		if (adv_s6 && v_s5) begin
			for (int p = 0; p < 2; p++) begin
				for (int k = 0; k < 5; k++) begin
					sum_s6[p][k] <= SUM_W'(prod_s5[p][2*k]) + SUM_W'(prod_s5[p][2*k+1]);
				end
			end
		end
		if (adv_s7 && v_s6) begin
			for (int p = 0; p < 2; p++) begin
				sum_s7[p][0] <= sum_s6[p][0] + sum_s6[p][1];
				sum_s7[p][1] <= sum_s6[p][2] + sum_s6[p][3];
				sum_s7[p][2] <= sum_s6[p][4];
			end
		end
		if (adv_s8 && v_s7) begin
			for (int p = 0; p < 2; p++) begin
				sum_s8[p][0] <= sum_s7[p][0] + sum_s7[p][1];
				sum_s8[p][1] <= sum_s7[p][2];
			end
		end
		if (adv_s9 && v_s8) begin
			for (int p = 0; p < 2; p++) begin
				sum_s9[p] <= sum_s8[p][0] + sum_s8[p][1];
			end
		end
		if (adv_s10 && v_s9) begin
			res_s10.src_x     <= clip[0];
			res_s10.src_y     <= clip[1];
			res_s10.saturated <= |sat;
		end
	end

	// round half up to the coefficient's fraction, then clip to 32 bits
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			rnd[p] = sum_s9[p] + HALF_S;
			rq[p]  = rnd[p][SUM_W-1:NORM_FRAC];
			if (rq[p] > R_MAX) begin
				clip[p] = SRC_MAX;
				sat[p]  = 1'b1;
			end else if (rq[p] < R_MIN) begin
				clip[p] = SRC_MIN;
				sat[p]  = 1'b1;
			end else begin
				clip[p] = rq[p][SRC_W-1:0];
				sat[p]  = 1'b0;
			end
		end
	end

	assign out_valid = v_s10;
	assign out_data  = res_s10;

	`ASSERT_NEXT(a_write_leaves_no_word, adv_s5 && in_valid && !in_data.tag.is_map,
		!v_s5, "write word entered the product stage")
	`ASSERT_IMPLY(a_sat_at_limit, v_s10 && res_s10.saturated,
		res_s10.src_x == SRC_MAX || res_s10.src_x == SRC_MIN ||
		res_s10.src_y == SRC_MAX || res_s10.src_y == SRC_MIN,
		"saturated flag without a clipped result")
	`ASSERT_NEXT(a_s9_holds, v_s9 && !adv_s9,
		v_s9 && $stable(sum_s9[0]) && $stable(sum_s9[1]),
		"stalled sum stage lost or changed its word")

endmodule

// ===== rtl/cubic_polynomial_warp_map.sv =====
// ------------------------------------------------------------------------
// cubic_polynomial_warp_map
// Inverse distortion map: cubic polynomials in normalized x and y give the
// source coordinates for each output pixel.
// ------------------------------------------------------------------------
//  channel | kind          | carries
//  --------+---------------+------------------------------------------------
//  req     | valid/ready   | cmd, coef_index, coef_value, column, row
//  rsp     | valid/ready   | src_x, src_y, saturated
//  cfg     | write only    | cfg_we, cfg_index, cfg_data (no wait)
//
//  One word per cycle enters unless a stalled rsp has backed up the pipeline. Ten
//  stages (two normalize, two monomial, one product, four adder tree, round/clip
//  output register): a map word's result is held in the output register until rsp takes it.
//  Write words update the coefficient store at the product stage and leave.
//  Each stage advances when the stage after it is empty or moving, so a stalled
//  rsp holds every word in place. Reset clears valid bits and loads register defaults.
// ------------------------------------------------------------------------
module cubic_polynomial_warp_map import cpwm_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cpwm_req_if.sink              req,
	cpwm_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	tag_t    req_tag;
	logic    nm_valid, nm_ready;
	norm_t   nm_data;
	logic    mo_valid, mo_ready;
	term_t   mo_data;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width   <= DIM_RST;
			cfg_q.height  <= DIM_RST;
			cfg_q.x_scale <= SCALE_RST;
			cfg_q.y_scale <= SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  cfg_q.width   <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: cfg_q.height  <= cfg_data[DIM_W-1:0];
				CFG_XSCALE: cfg_q.x_scale <= cfg_data[SCALE_W-1:0];
				CFG_YSCALE: cfg_q.y_scale <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign req_tag = '{is_map: (req.cmd == CMD_MAP), idx: req.coef_index,
		val: req.coef_value};

	cpwm_norm #(
		.COORD_BITS(COORD_BITS)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_tag   (req_tag),
		.in_col   (req.column),
		.in_row   (req.row),
		.out_valid(nm_valid),
		.out_ready(nm_ready),
		.out_data (nm_data)
	);

	cpwm_mono u_mono (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (nm_valid),
		.in_ready (nm_ready),
		.in_data  (nm_data),
		.out_valid(mo_valid),
		.out_ready(mo_ready),
		.out_data (mo_data)
	);

	cpwm_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mo_valid),
		.in_ready (mo_ready),
		.in_data  (mo_data),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_data (res)
	);

	assign rsp.src_x     = res.src_x;
	assign rsp.src_y     = res.src_y;
	assign rsp.saturated = res.saturated;

endmodule
